[src/sbpi_pkg.sv]
// Shared types and constants for the sample player.
package sbpi_pkg;
  localparam int ADDR_BITS   = 12;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int SPEED_BITS  = 8 + FRAC_BITS;
  localparam int LEN_BITS    = ADDR_BITS + 1;
  localparam int PH_BITS     = ADDR_BITS + FRAC_BITS;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = SPEED_BITS;
  localparam int QUEUE_DEPTH = 2;
  // Horner accumulator width: coefficients stay within about 12x the sample range.
  localparam int ACC_BITS = SAMPLE_BITS + 6;

  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_TICK  = 3'd1;
  localparam logic [2:0] REQ_PLAY  = 3'd2;
  localparam logic [2:0] REQ_PAUSE = 3'd3;
  localparam logic [2:0] REQ_STOP  = 3'd4;

  localparam logic [1:0] PM_ONESHOT  = 2'd0;
  localparam logic [1:0] PM_LOOP     = 2'd1;
  localparam logic [1:0] PM_PINGPONG = 2'd2;

  localparam logic [1:0] IM_NONE   = 2'd0;
  localparam logic [1:0] IM_LINEAR = 2'd1;
  localparam logic [1:0] IM_CUBIC  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PMODE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMODE  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH = 2'd3;

  typedef struct packed {
    logic [2:0]                    req_type;
    logic [ADDR_BITS-1:0]          write_addr;
    logic signed [SAMPLE_BITS-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          playing;
    logic [ADDR_BITS-1:0]          playhead_whole;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_WRITE, OP_TICK, OP_PLAY, OP_PAUSE, OP_STOP, OP_NOP
  } op_t;

  typedef struct packed {
    op_t                           op;
    logic [ADDR_BITS-1:0]          addr;
    logic signed [SAMPLE_BITS-1:0] data;
  } cmd_t;
endpackage

[src/sample_buffer_playhead_interp_top.sv]
// Top level of the mono sample player.
// Mono sample player: write transactions fill a 4096-entry sample memory; each tick
// transaction reads up to four taps at the Q12.16 playhead, interpolates (floor,
// linear or Catmull-Rom cubic), saturates, then advances the playhead by the signed
// Q8.16 speed under one-shot, loop or ping-pong end handling. Every input transaction
// yields exactly one result transaction. A front end decodes transactions into a
// two-entry queue; the back end runs one command at a time. A tick first reduces the
// tap base modulo the buffer length by sequenced subtraction, reads the taps through
// the single memory read port, runs the three Horner multiply steps, saturates and
// advances the playhead; in loop mode the new playhead is then brought into the buffer
// length by a sequenced modulo reduction. The next command is
// taken only once the previous result has been accepted. Configuration writes are
// accepted in any cycle and must only be issued while the block is idle.
module sample_buffer_playhead_interp_top import sbpi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  in_item_t                 in_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  output out_item_t                out_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  assign cfg_ready = 1'b1;

  sbpi_front u_front (
    .clk, .rst, .in_data, .in_valid, .in_ready,
    .cmd, .cmd_valid, .cmd_ready
  );

  sbpi_back u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_ready,
    .cfg_valid, .cfg_index, .cfg_data,
    .out_data, .out_valid, .out_ready
  );
endmodule

[src/sbpi_front.sv]
// Front end: accepts input transactions, decodes them and queues commands.
module sbpi_front import sbpi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_data,
  input  logic     in_valid,
  output logic     in_ready,
  output cmd_t     cmd,
  output logic     cmd_valid,
  input  logic     cmd_ready
);
  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  cmd_t q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [PTR_BITS:0]   count;
  cmd_t dec;

  always_comb begin
    dec.addr = in_data.write_addr;
    dec.data = in_data.write_data;
    unique case (in_data.req_type)
      REQ_WRITE: dec.op = OP_WRITE;
      REQ_TICK:  dec.op = OP_TICK;
      REQ_PLAY:  dec.op = OP_PLAY;
      REQ_PAUSE: dec.op = OP_PAUSE;
      REQ_STOP:  dec.op = OP_STOP;
      default:   dec.op = OP_NOP;
    endcase
  end

  assign in_ready  = (count != (PTR_BITS+1)'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q[wr_ptr] <= dec;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= wr_ptr + 1'b1;
      if (cmd_valid && cmd_ready) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_BITS+1)'(in_valid && in_ready)
                     - (PTR_BITS+1)'(cmd_valid && cmd_ready);
    end
  end
endmodule

[src/sbpi_back.sv]
// Back end: sample memory, interpolation sequencer and playhead update.
module sbpi_back import sbpi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  logic                     cfg_valid,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output out_item_t                out_data,
  output logic                     out_valid,
  input  logic                     out_ready
);
  localparam int F = FRAC_BITS;
  localparam int PW = PH_BITS + 3;  // signed room for playhead arithmetic
  localparam int MW = ACC_BITS + F + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_COEF, S_H1, S_H2, S_H3, S_FIN, S_ADV, S_WRAP,
    S_OUT
  } state_t;

  state_t state;
  logic signed [SAMPLE_BITS-1:0] mem [1<<ADDR_BITS];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic [ADDR_BITS-1:0] rd_addr;
  logic rd_en;

  logic [SPEED_BITS-1:0] speed;
  logic [1:0] pmode, imode;
  logic [LEN_BITS-1:0] blen;
  logic [PH_BITS-1:0] playhead;
  logic rev, run;
  logic signed [SAMPLE_BITS-1:0] held;

  logic signed [SAMPLE_BITS-1:0] p0, p1, p2, p3;
  logic [ADDR_BITS-1:0] base;
  logic signed [ACC_BITS-1:0] acc, c2, c1, c0;
  logic signed [MW-1:0] prod;
  logic [1:0] ridx;

  // effective length and wrapped tap addresses
  logic [LEN_BITS-1:0] len;
  logic [ADDR_BITS-1:0] whole_mod;
  always_comb begin
    len = blen;
    if (blen == '0) len = LEN_BITS'(1);
    if (blen > LEN_BITS'(1 << ADDR_BITS)) len = LEN_BITS'(1 << ADDR_BITS);
    // playhead whole part < 2^ADDR_BITS and len >= 1; loop reduction by one compare
    // is not enough in general, so base is reduced by a sequenced subtract in S_COEF.
    whole_mod = playhead[PH_BITS-1:F];
  end

  // tap address: base + k wrapped modulo len, k in -1..2
  function automatic logic [ADDR_BITS-1:0] tap_addr(input logic [ADDR_BITS-1:0] b,
                                                   input logic [1:0] k,
                                                   input logic [LEN_BITS-1:0] l);
    logic signed [LEN_BITS+1:0] t;
    t = $signed({2'b00, 1'b0, b}) + $signed((LEN_BITS+2)'(k)) - (LEN_BITS+2)'(1);
    if (t < 0) t = t + $signed({1'b0, 1'b0, l});
    if (t >= $signed({1'b0, 1'b0, l})) t = t - $signed({1'b0, 1'b0, l});
    if (t >= $signed({1'b0, 1'b0, l})) t = t - $signed({1'b0, 1'b0, l});
    return t[ADDR_BITS-1:0];
  endfunction

  logic [F-1:0] frac;
  assign frac = playhead[F-1:0];

  always_comb begin
    rd_en = 1'b0;
    rd_addr = tap_addr(base, ridx, len);
    unique case (state)
      S_RD0, S_RD1, S_RD2, S_RD3: rd_en = 1'b1;
      default: rd_en = 1'b0;
    endcase
  end

  // memory
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && cmd.op == OP_WRITE) mem[cmd.addr] <= cmd.data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Horner multiply, floor shift by F
  logic signed [MW-1:0] shifted;
  assign prod = $signed(MW'(acc)) * $signed({{(MW-F-1){1'b0}}, 1'b0, frac});
  assign shifted = prod >>> F;

  // linear step
  logic signed [SAMPLE_BITS+F+2:0] lprod;
  logic signed [SAMPLE_BITS+2:0] lres;
  assign lprod = ((SAMPLE_BITS+F+3)'(p2) - (SAMPLE_BITS+F+3)'(p1)) * $signed({3'b0, frac})
                 + (SAMPLE_BITS+F+3)'(1 << (F-1));

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [ACC_BITS+1:0] v);
    logic signed [ACC_BITS+1:0] hi, lo;
    hi = (ACC_BITS+2)'((1 << (SAMPLE_BITS-1)) - 1);
    lo = -hi - (ACC_BITS+2)'(1);
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

  // advance
  logic signed [PW-1:0] endv, stepv, pn, pp, pw;
  logic rev_n, run_n;
  always_comb begin
    endv  = $signed(PW'({len, {F{1'b0}}}));
    stepv = PW'($signed(speed));
    if (rev) stepv = -stepv;
    pn = $signed(PW'({1'b0, playhead})) + stepv;
    pp = pn;
    rev_n = rev;
    run_n = run;
    case (pmode)
      PM_ONESHOT: begin
        if (pn < 0 || pn >= endv) begin
          run_n = 1'b0;
          pp = '0;
        end
      end
      PM_PINGPONG: begin
        if (pp >= endv) begin
          pp = (endv <<< 1) - pp;
          rev_n = ~rev_n;
        end
        if (pp < 0) begin
          pp = -pp;
          rev_n = ~rev_n;
        end
        if (pp >= endv) pp = endv - PW'(1);
        if (pp < 0) pp = '0;
      end
      default: ;  // loop: reduced one length a cycle in S_WRAP
    endcase
  end

  assign cmd_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      speed <= SPEED_BITS'(1 << F);
      pmode <= PM_LOOP;
      imode <= IM_LINEAR;
      blen <= LEN_BITS'(1 << ADDR_BITS);
      playhead <= '0;
      rev <= 1'b0;
      run <= 1'b1;
      held <= '0;
      out_valid <= 1'b0;
      ridx <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SPEED:  speed <= cfg_data;
          CFG_PMODE: begin
            pmode <= cfg_data[1:0];
            rev <= 1'b0;
          end
          CFG_IMODE:  imode <= cfg_data[1:0];
          default:    blen <= cfg_data[LEN_BITS-1:0];
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            unique case (cmd.op)
              OP_TICK: begin
                if (run) begin
                  base <= whole_mod;
                  state <= S_COEF;  // reduce base first
                  ridx <= 2'd1;
                end else state <= S_OUT;
              end
              OP_PLAY:  begin run <= 1'b1; state <= S_OUT; end
              OP_PAUSE: begin run <= 1'b0; state <= S_OUT; end
              OP_STOP: begin
                run <= 1'b0;
                playhead <= '0;
                state <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_COEF: begin
          // base modulo len, one subtract a cycle
          if ({1'b0, base} >= len) base <= base - len[ADDR_BITS-1:0];
          else begin
            ridx <= 2'd1;
            state <= S_RD0;
          end
        end
        S_RD0: begin ridx <= 2'd2; state <= S_RD1; end
        S_RD1: begin p1 <= rd_data; ridx <= 2'd0; state <= S_RD2; end
        S_RD2: begin p2 <= rd_data; ridx <= 2'd3; state <= S_RD3; end
        S_RD3: begin p0 <= rd_data; state <= S_H1; end
        S_H1: begin
          p3 <= rd_data;
          state <= S_H2;
        end
        S_H2: begin
          acc <= ACC_BITS'(3 * (ACC_BITS'(p1) - ACC_BITS'(p2)) + ACC_BITS'(p3) - ACC_BITS'(p0));
          c2 <= ACC_BITS'(2 * ACC_BITS'(p0) - 5 * ACC_BITS'(p1) + 4 * ACC_BITS'(p2)
                          - ACC_BITS'(p3));
          c1 <= ACC_BITS'(ACC_BITS'(p2) - ACC_BITS'(p0));
          c0 <= ACC_BITS'(2 * ACC_BITS'(p1));
          ridx <= 2'd0;
          state <= S_H3;
        end
        S_H3: begin
          if (ridx == 2'd0) begin acc <= ACC_BITS'(shifted) + c2; ridx <= 2'd1; end
          else if (ridx == 2'd1) begin acc <= ACC_BITS'(shifted) + c1; ridx <= 2'd2; end
          else begin acc <= ACC_BITS'(shifted) + c0; state <= S_FIN; end
        end
        S_FIN: begin
          if (imode == IM_NONE) held <= p1;
          else if (imode == IM_CUBIC)
            held <= sat((ACC_BITS+2)'(acc + ACC_BITS'(1)) >>> 1);
          else held <= sat((ACC_BITS+2)'(lres));
          state <= S_ADV;
        end
        S_ADV: begin
          rev <= rev_n;
          run <= run_n;
          if (pmode == PM_ONESHOT || pmode == PM_PINGPONG) begin
            playhead <= pp[PH_BITS-1:0];
            state <= S_OUT;
          end else begin
            pw <= pn;
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          // loop: bring the new playhead into [0, end) one length a cycle
          if (pw >= endv) pw <= pw - endv;
          else if (pw < 0) pw <= pw + endv;
          else begin
            playhead <= pw[PH_BITS-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign lres = (SAMPLE_BITS+3)'(p1) + (SAMPLE_BITS+3)'(lprod >>> F);

  assign out_data.sample_out = held;
  assign out_data.playing = run;
  assign out_data.playhead_whole = playhead[PH_BITS-1:F];
endmodule
